FILE: rtl/core/kcl_pkg.sv
// Shared types, codes and segment tables for the keypad code lock display.
package kcl_pkg;

   // Lock modes, one-hot.
   typedef enum logic [3:0] {
      MODE_IDLE    = 4'b0001,
      MODE_ENTER   = 4'b0010,
      MODE_SUCCESS = 4'b0100,
      MODE_DENIED  = 4'b1000
   } mode_type;

   // Encoded lock state as reported in each result item.
   localparam logic [1:0] LOCK_IDLE    = 2'd0;
   localparam logic [1:0] LOCK_ENTER   = 2'd1;
   localparam logic [1:0] LOCK_SUCCESS = 2'd2;
   localparam logic [1:0] LOCK_DENIED  = 2'd3;

   localparam logic OP_POLL = 1'b0;
   localparam logic OP_TICK = 1'b1;

   localparam logic [4:0] KEY_NONE      = 5'h1F;
   localparam logic [4:0] KEY_DIGIT_MAX = 5'd9;
   localparam logic [4:0] KEY_HASH      = 5'd11;

   localparam logic [7:0] SEG_BLANK = 8'hFF;

   // Configuration register map.
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;
   localparam logic [CSR_INDEX_W-1:0] CSR_CODE_FIRST     = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CODE_SECOND    = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_CODE_THIRD     = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SUCCESS_TICKS  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_DENIED_TICKS   = 3'd4;

   // Slot index wide enough for every supported code length (up to eight places).
   localparam int SLOT_W = 3;
   // Count of scanned display positions; the longest message has seven.
   localparam int USE_W = 3;

   localparam int INTRO_LEN   = 5;
   localparam int SUCCESS_LEN = 7;
   localparam int DENIED_LEN  = 6;

   typedef struct packed {
      logic                   we;
      logic [CSR_INDEX_W-1:0] index;
      logic [CSR_DATA_W-1:0]  data;
   } csr_write_type;

   // Effects of one keypad item on the display side.
   typedef struct packed {
      logic              start_entry;
      logic              place;
      logic [SLOT_W-1:0] slot;
      logic [3:0]        digit;
      logic              load_success;
      logic              load_denied;
   } key_event_type;

   function automatic logic [1:0] lock_code(mode_type m);
      logic [1:0] code;
      case (m)
         MODE_IDLE:    code = LOCK_IDLE;
         MODE_ENTER:   code = LOCK_ENTER;
         MODE_SUCCESS: code = LOCK_SUCCESS;
         MODE_DENIED:  code = LOCK_DENIED;
         default:      code = LOCK_IDLE;
      endcase
      return code;
   endfunction

   function automatic logic [7:0] digit_seg(logic [3:0] d);
      logic [7:0] s;
      case (d)
         4'd0:    s = 8'hC0;
         4'd1:    s = 8'hF9;
         4'd2:    s = 8'hA4;
         4'd3:    s = 8'hB0;
         4'd4:    s = 8'h99;
         4'd5:    s = 8'h92;
         4'd6:    s = 8'h82;
         4'd7:    s = 8'hF8;
         4'd8:    s = 8'h80;
         4'd9:    s = 8'h90;
         default: s = SEG_BLANK;
      endcase
      return s;
   endfunction

   // "EntEr" followed by all-segments-lit zeros.
   function automatic logic [7:0] intro_seg(int i);
      logic [7:0] s;
      case (i)
         0:       s = 8'h86;
         1:       s = 8'hAB;
         2:       s = 8'h87;
         3:       s = 8'h86;
         4:       s = 8'hAF;
         default: s = 8'h00;
      endcase
      return s;
   endfunction

   function automatic logic [7:0] success_seg(int i);
      logic [7:0] s;
      case (i)
         0:       s = 8'h92;
         1:       s = 8'hC1;
         2:       s = 8'hC6;
         3:       s = 8'hC6;
         4:       s = 8'h86;
         5:       s = 8'h92;
         6:       s = 8'h92;
         default: s = SEG_BLANK;
      endcase
      return s;
   endfunction

   function automatic logic [7:0] denied_seg(int i);
      logic [7:0] s;
      case (i)
         0:       s = 8'hA1;
         1:       s = 8'h86;
         2:       s = 8'hAB;
         3:       s = 8'hF9;
         4:       s = 8'h86;
         5:       s = 8'hA1;
         default: s = SEG_BLANK;
      endcase
      return s;
   endfunction

endpackage

FILE: rtl/core/keypad_code_lock_display.sv
// An accepted item waits in the input register; its result is registered when it fires.
// Throughput: one item per cycle; while a result waits on rsp_ready the input register
// takes one more item and then holds req_ready low.
// Each item takes a single pass through the key decoder and the display scan.
// Reset is synchronous and active high; it loads the default code 1-2-3, the blink periods
// 200 and 500 ticks, idle mode and the "EntEr" message.
module keypad_code_lock_display
   import kcl_pkg::*;
#(
   parameter int DISPLAY_DIGITS = 8,
   parameter int CODE_LENGTH    = 3
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_opcode,
   input  logic signed [4:0]      req_scan_key,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [1:0]             rsp_lock_state,
   output logic [7:0]             rsp_digit_select_n,
   output logic [7:0]             rsp_segments_n,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   logic          in_valid_ff, in_op_ff;
   logic [4:0]    in_key_ff;
   logic          rsp_valid_ff;
   logic [1:0]    rsp_state_ff;
   logic [7:0]    rsp_select_ff, rsp_segment_ff;

   logic          fire;
   csr_write_type csr;
   mode_type      mode;
   logic [1:0]    lock_state_next;
   key_event_type evt;
   logic [7:0]    select_n, segment;

   assign csr.we    = csr_we;
   assign csr.index = csr_index;
   assign csr.data  = csr_wdata;

   // The held item is processed when the result register is free or being drained.
   assign fire      = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || fire;

   kcl_key_ctrl #(
      .CODE_LENGTH(CODE_LENGTH)
   ) u_key_ctrl (
      .clock          (clock),
      .reset          (reset),
      .csr            (csr),
      .poll           (fire && in_op_ff == OP_POLL),
      .key            (in_key_ff),
      .mode           (mode),
      .lock_state_next(lock_state_next),
      .evt            (evt)
   );

   kcl_display #(
      .DISPLAY_DIGITS(DISPLAY_DIGITS),
      .CODE_LENGTH   (CODE_LENGTH)
   ) u_display (
      .clock         (clock),
      .reset         (reset),
      .csr           (csr),
      .tick          (fire && in_op_ff == OP_TICK),
      .mode          (mode),
      .evt           (evt),
      .digit_select_n(select_n),
      .segments_n    (segment)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_valid && req_ready)
            in_valid_ff <= 1'b1;
         else if (fire)
            in_valid_ff <= 1'b0;
         if (fire)
            rsp_valid_ff <= 1'b1;
         else if (rsp_ready)
            rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_op_ff  <= req_opcode;
         in_key_ff <= req_scan_key;
      end
      if (fire) begin
         rsp_state_ff   <= lock_state_next;
         rsp_select_ff  <= (in_op_ff == OP_TICK) ? select_n : SEG_BLANK;
         rsp_segment_ff <= (in_op_ff == OP_TICK) ? segment : SEG_BLANK;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_lock_state     = rsp_state_ff;
   assign rsp_digit_select_n = rsp_select_ff;
   assign rsp_segments_n     = rsp_segment_ff;

`ifndef SYNTHESIS
   a_poll_blank: assert property (@(posedge clock) disable iff (reset)
      fire && in_op_ff == OP_POLL |=>
         rsp_digit_select_n == SEG_BLANK && rsp_segments_n == SEG_BLANK)
      else $error("poll item produced a lit display result");

   a_fire_result: assert property (@(posedge clock) disable iff (reset)
      fire |=> rsp_valid)
      else $error("processed item did not produce a result");

   a_one_cold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_digit_select_n != SEG_BLANK |->
         $countones(~rsp_digit_select_n) == 1)
      else $error("more than one digit selected");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> in_valid_ff && rsp_valid && !rsp_ready)
      else $error("input stalled without a blocked result");
`endif

endmodule

FILE: rtl/core/kcl_key_ctrl.sv
// Keypad decoding, code entry and the lock mode machine.
module kcl_key_ctrl
   import kcl_pkg::*;
#(
   parameter int CODE_LENGTH = 3
) (
   input  logic          clock,
   input  logic          reset,
   input  csr_write_type csr,
   input  logic          poll,
   input  logic [4:0]    key,
   output mode_type      mode,
   output logic [1:0]    lock_state_next,
   output key_event_type evt
);

   localparam int ENTRY_W = $clog2(CODE_LENGTH + 1);

   mode_type          mode_ff, mode_in;
   logic [4:0]        prev_key_ff;
   logic [ENTRY_W-1:0] entry_count_ff, entry_count_in, count_eff;
   logic [3:0]        entered_ff [CODE_LENGTH];
   logic [3:0]        code_first_ff, code_second_ff, code_third_ff;

   logic counted, is_digit, is_hash, start_entry, place, hash_take, match;

   function automatic logic [3:0] code_digit(int i, logic [3:0] c0, logic [3:0] c1,
                                             logic [3:0] c2);
      logic [3:0] d;
      case (i)
         0:       d = c0;
         1:       d = c1;
         2:       d = c2;
         default: d = 4'd0;
      endcase
      return d;
   endfunction

   always_comb begin
      // A press counts only on a change to a pressed key.
      counted     = poll && (key != prev_key_ff) && (key != KEY_NONE);
      is_digit    = !key[4] && (key <= KEY_DIGIT_MAX);
      is_hash     = (key == KEY_HASH);
      start_entry = counted && is_digit && (mode_ff != MODE_ENTER);
      count_eff   = start_entry ? '0 : entry_count_ff;
      place       = counted && is_digit && (count_eff < ENTRY_W'(CODE_LENGTH));
      hash_take   = counted && is_hash && (mode_ff == MODE_ENTER);

      match = (entry_count_ff == ENTRY_W'(CODE_LENGTH));
      for (int i = 0; i < CODE_LENGTH; i++) begin
         if (entered_ff[i] != code_digit(i, code_first_ff, code_second_ff, code_third_ff))
            match = 1'b0;
      end

      mode_in = mode_ff;
      if (start_entry)
         mode_in = MODE_ENTER;
      else if (hash_take)
         mode_in = match ? MODE_SUCCESS : MODE_DENIED;

      entry_count_in = count_eff + ENTRY_W'(place);

      evt.start_entry  = start_entry;
      evt.place        = place;
      evt.slot         = SLOT_W'(count_eff);
      evt.digit        = key[3:0];
      evt.load_success = hash_take && match;
      evt.load_denied  = hash_take && !match;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= MODE_IDLE;
         prev_key_ff    <= KEY_NONE;
         entry_count_ff <= '0;
         code_first_ff  <= 4'd1;
         code_second_ff <= 4'd2;
         code_third_ff  <= 4'd3;
      end else begin
         mode_ff        <= mode_in;
         entry_count_ff <= entry_count_in;
         if (poll)
            prev_key_ff <= key;
         if (csr.we) begin
            case (csr.index)
               CSR_CODE_FIRST:  code_first_ff  <= csr.data[3:0];
               CSR_CODE_SECOND: code_second_ff <= csr.data[3:0];
               CSR_CODE_THIRD:  code_third_ff  <= csr.data[3:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < CODE_LENGTH; i++) begin
         if (place && count_eff == ENTRY_W'(i))
            entered_ff[i] <= key[3:0];
      end
   end

   assign mode            = mode_ff;
   assign lock_state_next = lock_code(mode_in);

endmodule

FILE: rtl/core/kcl_display.sv
// Display store, digit scan and blink timing for the multiplexed display.
module kcl_display
   import kcl_pkg::*;
#(
   parameter int DISPLAY_DIGITS = 8,
   parameter int CODE_LENGTH    = 3
) (
   input  logic          clock,
   input  logic          reset,
   input  csr_write_type csr,
   input  logic          tick,
   input  mode_type      mode,
   input  key_event_type evt,
   output logic [7:0]    digit_select_n,
   output logic [7:0]    segments_n
);

   localparam int SCAN_W = $clog2(DISPLAY_DIGITS);

   logic [7:0]        store_ff [DISPLAY_DIGITS];
   logic [USE_W-1:0]  in_use_ff;
   logic [SCAN_W-1:0] pos_ff, pos_in;
   logic [15:0]       blink_count_ff, blink_count_in;
   logic              blink_off_ff, blink_off_in;
   logic [15:0]       success_ticks_ff, denied_ticks_ff, period;

   logic              blinking, blink_done, shown, reload;
   logic [SCAN_W:0]   pos_inc;

   always_comb begin
      blinking   = (mode == MODE_SUCCESS) || (mode == MODE_DENIED);
      period     = (mode == MODE_SUCCESS) ? success_ticks_ff : denied_ticks_ff;
      // A period of zero behaves as one: the compare is always met.
      blink_done = ({1'b0, blink_count_ff} + 17'd1) >= {1'b0, period};
      reload     = evt.load_success || evt.load_denied;

      blink_count_in = blink_count_ff;
      blink_off_in   = blink_off_ff;
      if (reload) begin
         blink_count_in = '0;
         blink_off_in   = 1'b0;
      end else if (tick && blinking) begin
         blink_count_in = blink_done ? 16'd0 : blink_count_ff + 16'd1;
         blink_off_in   = blink_done ? !blink_off_ff : blink_off_ff;
      end

      shown = !blinking || !blink_off_in;

      pos_inc = {1'b0, pos_ff} + (SCAN_W + 1)'(1);
      pos_in  = pos_ff;
      if (evt.start_entry || reload)
         pos_in = '0;
      else if (tick) begin
         if (pos_inc >= (SCAN_W + 1)'(in_use_ff) || pos_inc >= (SCAN_W + 1)'(DISPLAY_DIGITS))
            pos_in = '0;
         else
            pos_in = pos_inc[SCAN_W-1:0];
      end

      for (int b = 0; b < 8; b++)
         digit_select_n[b] = !(shown && pos_ff == SCAN_W'(b));
      segments_n = shown ? store_ff[pos_ff] : SEG_BLANK;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DISPLAY_DIGITS; i++)
            store_ff[i] <= intro_seg(i);
         in_use_ff        <= USE_W'(INTRO_LEN);
         pos_ff           <= '0;
         blink_count_ff   <= '0;
         blink_off_ff     <= 1'b0;
         success_ticks_ff <= 16'd200;
         denied_ticks_ff  <= 16'd500;
      end else begin
         pos_ff         <= pos_in;
         blink_count_ff <= blink_count_in;
         blink_off_ff   <= blink_off_in;
         // The first digit of a new entry lands in a position that is otherwise blanked.
         for (int i = 0; i < DISPLAY_DIGITS; i++) begin
            if (evt.place && i < CODE_LENGTH && evt.slot == SLOT_W'(i))
               store_ff[i] <= digit_seg(evt.digit);
            else if (evt.start_entry)
               store_ff[i] <= SEG_BLANK;
            else if (evt.load_success && i < SUCCESS_LEN)
               store_ff[i] <= success_seg(i);
            else if (evt.load_denied && i < DENIED_LEN)
               store_ff[i] <= denied_seg(i);
         end
         if (evt.start_entry)
            in_use_ff <= USE_W'(CODE_LENGTH);
         else if (evt.load_success)
            in_use_ff <= USE_W'(SUCCESS_LEN);
         else if (evt.load_denied)
            in_use_ff <= USE_W'(DENIED_LEN);
         if (csr.we) begin
            case (csr.index)
               CSR_SUCCESS_TICKS: success_ticks_ff <= csr.data;
               CSR_DENIED_TICKS:  denied_ticks_ff  <= csr.data;
               default: ;
            endcase
         end
      end
   end

endmodule
